FILE: rtl/pee_pkg.sv
// Package for the prefix expression evaluator core.
// Holds the character codes and status codes shared by the core and its users.
// No dependencies.
package pee_pkg;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_DIV0    = 3'd1,
		ST_BADCHAR = 3'd2,
		ST_UNDER   = 3'd3,
		ST_OVER    = 3'd4
	} status_t;

endpackage

FILE: rtl/prefix_expression_evaluator_core.sv
// Prefix expression evaluator: a character sequencer, an operand stack memory and one shared
// adder/subtractor that runs the multiply and divide one bit per cycle.
// Depends on pee_pkg (character codes, status codes).
//
// Characters arrive one per transaction, last character first; final_item marks the first
// character and causes one result transaction. in_stall stays high while a character is in
// work: a digit is added into the number, a space pushes a pending number, and any other
// character pushes it, pops two operands, runs + and - once on the shared adder and * and /
// bit by bit, then pushes any result. A pop that finds the stack empty skips the memory
// read. Each pop goes through the registered memory read, and the shared adder runs one
// multiplier or quotient bit per cycle. The core then returns to idle, where the next
// character is taken. The final item also flushes the number, pops the result and loads
// the result register, and holds longer while an earlier result still waits. The result
// register lets the next expression start while a result waits to be taken. On a divide
// by zero or an unknown character the result is -1; the rest of the expression is skipped.
module prefix_expression_evaluator_core #(
	parameter int STACK_DEPTH = 64,
	parameter int DATA_WIDTH  = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         char_code,
	input  logic               final_item,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] result_value,
	output logic [2:0]         status
);

	localparam int DW = DATA_WIDTH;
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int SW = $clog2(DATA_WIDTH);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_POPA,
		S_TAKEA,
		S_POPB,
		S_TAKEB,
		S_OP,
		S_MUL,
		S_DIV,
		S_DIVEND,
		S_PUSH,
		S_FINISH,
		S_FIN_FLUSH,
		S_FIN_POP,
		S_FIN_TAKE,
		S_OUT
	} state_t;

	state_t            state_q;
	logic [7:0]        char_q;
	logic              final_q;
	logic [CW-1:0]     cnt_q;
	logic [DW-1:0]     acc_q;
	logic [DW-1:0]     wgt_q;
	logic              inside_q;
	pee_pkg::status_t  err_q;
	logic [DW-1:0]     opa_q;
	logic [DW-1:0]     opb_q;
	logic [DW-1:0]     res_q;
	logic [DW-1:0]     rem_q;
	logic              sign_q;
	logic [SW-1:0]     stp_q;
	logic [DW-1:0]     rd_q;
	logic              out_valid_q;
	logic signed [31:0] out_value_q;
	pee_pkg::status_t  out_status_q;

	logic [DW-1:0] stack_mem [STACK_DEPTH];

	logic              fatal;
	logic              is_digit;
	logic [3:0]        digit;
	logic [DW-1:0]     digit_term;
	logic              push_req;
	logic              push_ok;
	logic [DW-1:0]     push_data;
	logic              pop_req;
	logic              pop_ok;
	logic [AW-1:0]     rd_addr;
	logic [DW+1:0]     alu_x;
	logic [DW+1:0]     alu_y;
	logic              alu_sub;
	logic [DW+1:0]     alu_r;
	logic signed [DW-1:0] res_s;

	assign fatal    = (err_q == pee_pkg::ST_DIV0) || (err_q == pee_pkg::ST_BADCHAR);
	assign is_digit = (char_q >= pee_pkg::CH_ZERO) && (char_q <= pee_pkg::CH_NINE);
	assign digit    = char_q[3:0];
	assign digit_term = ({DW{digit[0]}} & wgt_q) + ({DW{digit[1]}} & (wgt_q << 1))
		+ ({DW{digit[2]}} & (wgt_q << 2)) + ({DW{digit[3]}} & (wgt_q << 3));

	always_comb begin
		push_req = 1'b0;
		pop_req  = 1'b0;
		case (state_q)
			S_DISPATCH:  push_req = !fatal && !is_digit && inside_q;
			S_FIN_FLUSH: push_req = inside_q;
			S_PUSH:      push_req = 1'b1;
			S_POPA, S_POPB, S_FIN_POP: pop_req = 1'b1;
			default: begin
				push_req = 1'b0;
				pop_req  = 1'b0;
			end
		endcase
	end

	assign push_ok   = push_req && (cnt_q < CW'(STACK_DEPTH));
	assign push_data = (state_q == S_PUSH) ? res_q : acc_q;
	assign pop_ok    = pop_req && (cnt_q != '0);
	assign rd_addr   = AW'(cnt_q - CW'(1));

	always_comb begin
		alu_x   = {2'b00, opa_q};
		alu_y   = {2'b00, opb_q};
		alu_sub = (char_q == pee_pkg::CH_MINUS);
		case (state_q)
			S_MUL: begin
				alu_x   = {2'b00, res_q};
				alu_y   = {2'b00, opa_q};
				alu_sub = 1'b0;
			end
			S_DIV: begin
				alu_x   = {1'b0, rem_q, opa_q[DW-1]};
				alu_y   = {2'b00, opb_q};
				alu_sub = 1'b1;
			end
			default: begin
				alu_x   = {2'b00, opa_q};
				alu_y   = {2'b00, opb_q};
				alu_sub = (char_q == pee_pkg::CH_MINUS);
			end
		endcase
	end

	assign alu_r = alu_x + (alu_sub ? ~alu_y : alu_y) + (DW + 2)'(alu_sub);
	assign res_s = res_q;

	always_ff @(posedge clk) begin
		if (push_ok)
			stack_mem[cnt_q[AW-1:0]] <= push_data;
		if (pop_ok)
			rd_q <= stack_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			char_q       <= '0;
			final_q      <= 1'b0;
			cnt_q        <= '0;
			acc_q        <= '0;
			wgt_q        <= DW'(1);
			inside_q     <= 1'b0;
			err_q        <= pee_pkg::ST_OK;
			opa_q        <= '0;
			opb_q        <= '0;
			res_q        <= '0;
			rem_q        <= '0;
			sign_q       <= 1'b0;
			stp_q        <= '0;
			out_valid_q  <= 1'b0;
			out_value_q  <= '0;
			out_status_q <= pee_pkg::ST_OK;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_OUT)
				out_valid_q <= 1'b0;
			if (push_ok)
				cnt_q <= cnt_q + CW'(1);
			else if (push_req && err_q == pee_pkg::ST_OK)
				err_q <= pee_pkg::ST_OVER;
			if (pop_ok)
				cnt_q <= cnt_q - CW'(1);
			else if (pop_req && err_q == pee_pkg::ST_OK)
				err_q <= pee_pkg::ST_UNDER;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						char_q  <= char_code;
						final_q <= final_item;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					if (fatal) begin
						state_q <= S_FINISH;
					end else begin
						case (char_q) inside
							[pee_pkg::CH_ZERO:pee_pkg::CH_NINE]: begin
								acc_q    <= acc_q + digit_term;
								wgt_q    <= (wgt_q << 3) + (wgt_q << 1);
								inside_q <= 1'b1;
								state_q  <= S_FINISH;
							end
							pee_pkg::CH_SPACE: begin
								acc_q    <= '0;
								wgt_q    <= DW'(1);
								inside_q <= 1'b0;
								state_q  <= S_FINISH;
							end
							default: begin
								acc_q    <= '0;
								wgt_q    <= DW'(1);
								inside_q <= 1'b0;
								state_q  <= S_POPA;
							end
						endcase
					end
				end
				S_POPA: begin
					opa_q   <= '1;
					state_q <= pop_ok ? S_TAKEA : S_POPB;
				end
				S_TAKEA: begin
					opa_q   <= rd_q;
					state_q <= S_POPB;
				end
				S_POPB: begin
					opb_q   <= '1;
					state_q <= pop_ok ? S_TAKEB : S_OP;
				end
				S_TAKEB: begin
					opb_q   <= rd_q;
					state_q <= S_OP;
				end
				S_OP: begin
					case (char_q)
						pee_pkg::CH_PLUS, pee_pkg::CH_MINUS: begin
							res_q   <= alu_r[DW-1:0];
							state_q <= S_PUSH;
						end
						pee_pkg::CH_STAR: begin
							res_q   <= '0;
							stp_q   <= SW'(DW - 1);
							state_q <= S_MUL;
						end
						pee_pkg::CH_SLASH: begin
							if (opb_q == '0) begin
								err_q   <= pee_pkg::ST_DIV0;
								state_q <= S_FINISH;
							end else begin
								opa_q   <= opa_q[DW-1] ? (~opa_q + DW'(1)) : opa_q;
								opb_q   <= opb_q[DW-1] ? (~opb_q + DW'(1)) : opb_q;
								sign_q  <= opa_q[DW-1] ^ opb_q[DW-1];
								rem_q   <= '0;
								stp_q   <= SW'(DW - 1);
								state_q <= S_DIV;
							end
						end
						default: begin
							err_q   <= pee_pkg::ST_BADCHAR;
							state_q <= S_FINISH;
						end
					endcase
				end
				S_MUL: begin
					if (opb_q[0])
						res_q <= alu_r[DW-1:0];
					opa_q <= opa_q << 1;
					opb_q <= opb_q >> 1;
					stp_q <= stp_q - SW'(1);
					if (stp_q == '0)
						state_q <= S_PUSH;
				end
				S_DIV: begin
					if (!alu_r[DW+1]) begin
						rem_q <= alu_r[DW-1:0];
						opa_q <= {opa_q[DW-2:0], 1'b1};
					end else begin
						rem_q <= alu_x[DW-1:0];
						opa_q <= {opa_q[DW-2:0], 1'b0};
					end
					stp_q <= stp_q - SW'(1);
					if (stp_q == '0)
						state_q <= S_DIVEND;
				end
				S_DIVEND: begin
					res_q   <= sign_q ? (~opa_q + DW'(1)) : opa_q;
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (!final_q)
						state_q <= S_IDLE;
					else if (fatal)
						state_q <= S_OUT;
					else
						state_q <= S_FIN_FLUSH;
				end
				S_FIN_FLUSH: begin
					acc_q    <= '0;
					wgt_q    <= DW'(1);
					inside_q <= 1'b0;
					state_q  <= S_FIN_POP;
				end
				S_FIN_POP: begin
					res_q   <= '1;
					state_q <= pop_ok ? S_FIN_TAKE : S_OUT;
				end
				S_FIN_TAKE: begin
					res_q   <= rd_q;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						out_value_q  <= fatal ? '1 : 32'(res_s);
						out_status_q <= err_q;
						cnt_q        <= '0;
						acc_q        <= '0;
						wgt_q        <= DW'(1);
						inside_q     <= 1'b0;
						err_q        <= pee_pkg::ST_OK;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall     = (state_q != S_IDLE);
	assign out_valid    = out_valid_q;
	assign result_value = out_value_q;
	assign status       = out_status_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(STACK_DEPTH))
		else $error("operand stack count beyond depth");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while a character is in work");

	a_fatal_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == pee_pkg::ST_DIV0 || status == pee_pkg::ST_BADCHAR))
		|-> (result_value == -32'sd1))
		else $error("fatal status without -1 result");

	a_fatal_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(fatal && state_q != S_OUT) |=> (err_q == $past(err_q)))
		else $error("fatal status changed before the result");

	a_push_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		push_ok |-> (cnt_q < CW'(STACK_DEPTH)))
		else $error("stack write past the top");
`endif

endmodule

FILE: tb/prefix_expression_evaluator_core_test.sv
// Testbench for prefix_expression_evaluator_core: sends prefix expressions last character
// first, predicts each result with its own stack evaluator and checks every result transaction.
// Depends on pee_pkg and the core RTL.
module prefix_expression_evaluator_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STACK_DEPTH = 64;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		logic [31:0]      value;
		pee_pkg::status_t code;
	} eval_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         char_code = 8'd0;
	logic               final_item = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] result_value;
	logic [2:0]         status;

	prefix_expression_evaluator_core #(
		.STACK_DEPTH(STACK_DEPTH),
		.DATA_WIDTH (32)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.char_code   (char_code),
		.final_item  (final_item),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_value(result_value),
		.status      (status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// evaluator state
	logic [31:0]       operand_mem [STACK_DEPTH];
	int unsigned       operand_count;
	logic [31:0]       num_acc;
	logic [31:0]       place_wt;
	bit                in_number;
	pee_pkg::status_t  err_code;

	eval_result_t result_fifo [$];
	eval_result_t want;
	logic [7:0]   expr_chars [$];

	int error_count = 0;
	int cycle_count = 0;
	int items_sent = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int stall_hold = 0;

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_v);
		if (error_count < 40)
			$display("MISMATCH %s: got %0d expected %0d", what, $signed(got), $signed(exp_v));
		error_count++;
	endtask

	function automatic void clear_state();
		operand_count = 0;
		num_acc = 32'd0;
		place_wt = 32'd1;
		in_number = 1'b0;
		err_code = pee_pkg::ST_OK;
	endfunction

	function automatic bit fatal_seen();
		return err_code == pee_pkg::ST_DIV0 || err_code == pee_pkg::ST_BADCHAR;
	endfunction

	function automatic void stack_push(logic [31:0] v);
		if (operand_count >= STACK_DEPTH) begin
			if (err_code == pee_pkg::ST_OK)
				err_code = pee_pkg::ST_OVER;
		end else begin
			operand_mem[operand_count] = v;
			operand_count++;
		end
	endfunction

	function automatic logic [31:0] stack_pop();
		if (operand_count == 0) begin
			if (err_code == pee_pkg::ST_OK)
				err_code = pee_pkg::ST_UNDER;
			return '1;
		end
		operand_count--;
		return operand_mem[operand_count];
	endfunction

	function automatic void flush_number();
		if (in_number) begin
			stack_push(num_acc);
			num_acc = 32'd0;
			place_wt = 32'd1;
			in_number = 1'b0;
		end
	endfunction

	function automatic logic [31:0] signed_quotient(logic [31:0] num, logic [31:0] den);
		logic [31:0] mag_n, mag_d, q;
		mag_n = num[31] ? -num : num;
		mag_d = den[31] ? -den : den;
		q = mag_n / mag_d;
		return (num[31] ^ den[31]) ? -q : q;
	endfunction

	function automatic void apply_char(logic [7:0] c);
		logic [31:0] a, b, r;
		if (fatal_seen())
			return;
		if (c >= pee_pkg::CH_ZERO && c <= pee_pkg::CH_NINE) begin
			num_acc = num_acc + {24'd0, c - pee_pkg::CH_ZERO} * place_wt;
			place_wt = place_wt * 32'd10;
			in_number = 1'b1;
			return;
		end
		flush_number();
		if (c == pee_pkg::CH_SPACE)
			return;
		a = stack_pop();
		b = stack_pop();
		case (c)
			pee_pkg::CH_PLUS: r = a + b;
			pee_pkg::CH_MINUS: r = a - b;
			pee_pkg::CH_STAR: r = a * b;
			pee_pkg::CH_SLASH: begin
				if (b == 32'd0) begin
					err_code = pee_pkg::ST_DIV0;
					return;
				end
				r = signed_quotient(a, b);
			end
			default: begin
				err_code = pee_pkg::ST_BADCHAR;
				return;
			end
		endcase
		stack_push(r);
	endfunction

	function automatic void predict_item(logic [7:0] c, bit fin);
		eval_result_t res;
		apply_char(c);
		if (fin) begin
			if (fatal_seen()) begin
				res.value = '1;
			end else begin
				flush_number();
				res.value = stack_pop();
			end
			res.code = err_code;
			result_fifo.push_back(res);
			clear_state();
		end
	endfunction

	task automatic send_char(logic [7:0] c, bit fin);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_code <= c;
		final_item <= fin;
		do @(posedge clk); while (in_stall);
		predict_item(c, fin);
		items_sent++;
	endtask

	// send back to front; the first character closes the expression
	task automatic send_expression();
		for (int i = expr_chars.size() - 1; i >= 0; i--)
			send_char(expr_chars[i], i == 0);
		expr_chars.delete();
	endtask

	function automatic void load_text(string s);
		for (int i = 0; i < s.len(); i++)
			expr_chars.push_back(s[i]);
	endfunction

	function automatic logic [7:0] pick_op();
		case ($urandom_range(0, 3))
			0: return pee_pkg::CH_PLUS;
			1: return pee_pkg::CH_MINUS;
			2: return pee_pkg::CH_STAR;
			default: return pee_pkg::CH_SLASH;
		endcase
	endfunction

	function automatic void put_spaces(int unsigned lo, int unsigned hi);
		repeat ($urandom_range(hi, lo)) expr_chars.push_back(pee_pkg::CH_SPACE);
	endfunction

	function automatic void put_number();
		int unsigned ndig;
		ndig = ($urandom_range(0, 15) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
		repeat (ndig) expr_chars.push_back(pee_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
	endfunction

	function automatic void put_expr(int unsigned lvl);
		if (lvl == 0 || $urandom_range(0, 3) == 0) begin
			put_number();
		end else begin
			expr_chars.push_back(pick_op());
			put_spaces(0, 1);
			put_expr(lvl - 1);
			put_spaces(1, 2);
			put_expr(lvl - 1);
		end
	endfunction

	function automatic void make_random_expression();
		int unsigned kind;
		kind = $urandom_range(0, 99);
		if (kind < 65) begin
			put_expr($urandom_range(0, 5));
		end else if (kind < 75) begin
			put_expr($urandom_range(1, 4));
			expr_chars.insert($urandom_range(0, expr_chars.size()), 8'($urandom_range(0, 255)));
		end else if (kind < 85) begin
			repeat ($urandom_range(1, 10)) begin
				case ($urandom_range(0, 2))
					0: expr_chars.push_back(pick_op());
					1: put_number();
					default: put_spaces(1, 2);
				endcase
			end
		end else if (kind < 92) begin
			repeat ($urandom_range(1, 8)) expr_chars.push_back(8'($urandom_range(0, 255)));
		end else begin
			put_spaces(1, 3);
			put_expr(3);
			put_spaces(1, 3);
		end
	endfunction

	task automatic test_directed();
		load_text("*9 7");
		send_expression();
		load_text("/7 0");
		send_expression();
		load_text("+");
		send_expression();
		expr_chars.push_back(8'hFF);
		send_expression();
		load_text("-4 9");
		send_expression();
		load_text("/2147483648");
		send_expression();
	endtask

	// fill the stack exactly, then one past full
	task automatic test_stack_depth();
		for (int n = STACK_DEPTH; n <= STACK_DEPTH + 1; n++) begin
			repeat (n - 1) expr_chars.push_back(pick_op());
			for (int i = 0; i < n; i++) begin
				expr_chars.push_back(pee_pkg::CH_ZERO + 8'($urandom_range(1, 9)));
				if (i < n - 1)
					expr_chars.push_back(pee_pkg::CH_SPACE);
			end
			send_expression();
		end
	endtask

	task automatic test_random_traffic(int send_pct, int recv_pct, int item_goal);
		int start;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		start = items_sent;
		while (items_sent - start < item_goal) begin
			make_random_expression();
			send_expression();
		end
	endtask

	// hold the result side while short expressions keep coming
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		stall_hold = 400;
		repeat (8) begin
			put_expr(1);
			send_expression();
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (result_fifo.size() == 0) begin
				report_mismatch("unexpected result", result_value, 32'd0);
			end else begin
				want = result_fifo.pop_front();
				if (result_value !== want.value)
					report_mismatch("result_value", result_value, want.value);
				if (status !== want.code)
					report_mismatch("status", {29'd0, status}, {29'd0, want.code});
			end
		end
		out_stall <= (stall_hold > 0) || ($urandom_range(0, 99) < recv_stall_pct);
		if (stall_hold > 0)
			stall_hold--;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		clear_state();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_stack_depth();
		test_random_traffic(14, 66, 450);
		test_random_traffic(66, 14, 450);
		test_random_traffic(0, 0, 450);
		test_backpressure();
		in_valid <= 1'b0;
		while (result_fifo.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
